### sv/rlve_pkg.sv
// Shared types, constants and the run-to-bytes coding function for the
// run-length value encoder. No dependencies.
package rlve_pkg;

  localparam logic [7:0]  RunCap    = 8'd255;
  localparam logic [15:0] ShortMask = 16'hFF80;
  localparam logic [15:0] ValueSat  = 16'h7FFF;
  localparam logic [7:0]  LongMark  = 8'h80;

  localparam int unsigned MaxBytes  = 6;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);

  // Bytes of one closed run: count byte, then one or two value bytes.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      len;
  } run_bytes_t;

  // One queued command: all bytes caused by one input item.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               len;
    logic                     last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } front_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic run_bytes_t build_run(input logic [7:0] cnt, input logic [15:0] val);
    run_bytes_t  r;
    logic [15:0] sat;
    sat = val[15] ? ValueSat : val;
    r.bytes[0] = cnt;
    if ((val & ShortMask) == 16'd0) begin
      r.bytes[1] = val[7:0];
      r.bytes[2] = 8'd0;
      r.len      = 2'd2;
    end else begin
      r.bytes[1] = LongMark | sat[15:8];
      r.bytes[2] = sat[7:0];
      r.len      = 2'd3;
    end
    return r;
  endfunction

endpackage

### sv/rlve_front.sv
// Front end: run tracking and classification of each accepted value.
// Builds the complete byte command for the item. Depends on rlve_pkg.
module rlve_front import rlve_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [15:0] sample_value_i,
  input  logic        final_sample_i,
  output front_req_t  req_o
);

  logic [15:0] held_q, held_d;
  logic [7:0]  count_q, count_d;

  always_comb begin
    logic [15:0] new_held;
    logic [7:0]  new_count;
    logic        has_a;
    run_bytes_t  ra, rb;
    logic [2:0]  off, j, len_b;

    has_a     = 1'b0;
    new_held  = sample_value_i;
    new_count = 8'd1;
    if (count_q == 8'd0) begin
      has_a = 1'b0;
    end else if (sample_value_i == held_q && count_q < RunCap) begin
      new_held  = held_q;
      new_count = count_q + 8'd1;
    end else begin
      has_a = 1'b1;
    end

    ra    = build_run(count_q, held_q);
    rb    = build_run(new_count, new_held);
    off   = has_a ? {1'b0, ra.len} : 3'd0;
    len_b = final_sample_i ? {1'b0, rb.len} : 3'd0;

    req_o.valid    = accept_i & (has_a | final_sample_i);
    req_o.cmd.len  = off + len_b;
    req_o.cmd.last = final_sample_i;
    for (int i = 0; i < MaxBytes; i++) begin
      j = 3'(i) - off;
      if (has_a && (3'(i) < {1'b0, ra.len})) begin
        req_o.cmd.bytes[i] = ra.bytes[j[1:0] + 2'(off)];
      end else if (j < 3'd3) begin
        req_o.cmd.bytes[i] = rb.bytes[j[1:0]];
      end else begin
        req_o.cmd.bytes[i] = 8'd0;
      end
    end

    held_d  = held_q;
    count_d = count_q;
    if (accept_i) begin
      held_d  = final_sample_i ? 16'd0 : new_held;
      count_d = final_sample_i ? 8'd0 : new_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      count_q <= '0;
    end else begin
      held_q  <= held_d;
      count_q <= count_d;
    end
  end

endmodule

### sv/rlve_fifo.sv
// Command queue between front end and serializer.
// Depth from rlve_pkg::FifoDepth. Depends on rlve_pkg.
module rlve_fifo import rlve_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  front_req_t req_i,
  input  logic       pop_i,
  output cmd_t       head_o,
  output fifo_stat_t stat_o
);

  cmd_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_q, rd_q;
  logic [FifoCw-1:0] cnt_q;
  logic              wr_en, rd_en;

  assign stat_o.full  = (cnt_q == FifoCw'(FifoDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign wr_en        = req_i.valid & ~stat_o.full;
  assign rd_en        = pop_i & ~stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= req_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wr_q <= (wr_q == FifoAw'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (rd_en) begin
        rd_q <= (rd_q == FifoAw'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + FifoCw'(wr_en) - FifoCw'(rd_en);
    end
  end

endmodule

### sv/rlve_back.sv
// Back end: serializes one queued command into output bytes, one per transfer.
// Depends on rlve_pkg.
module rlve_back import rlve_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       head_i,
  input  logic       head_valid_i,
  output logic       head_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       item_done_o,
  output logic       stream_done_o
);

  cmd_t       cmd_q;
  logic       valid_q;
  logic [2:0] idx_q;
  logic       last_byte, take, done;

  assign last_byte     = (idx_q == cmd_q.len - 3'd1);
  assign take          = pop_i & valid_q;
  assign done          = take & last_byte;
  assign head_pop_o    = head_valid_i & (~valid_q | done);
  assign empty_o       = ~valid_q;
  assign out_byte_o    = cmd_q.bytes[idx_q];
  assign item_done_o   = last_byte;
  assign stream_done_o = last_byte & cmd_q.last;

  always_ff @(posedge clk_i) begin
    if (head_pop_o) begin
      cmd_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (head_pop_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (done) begin
      valid_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + 3'd1;
    end
  end

endmodule

### sv/run_length_value_encoder_core.sv
// Run-length value encoder, top level.
// Throughput: one value per cycle while the command queue has room; the input
// stalls only on a full queue. Output runs at one byte per cycle while pop is
// high and a command is ready, with no gap between commands; an item emits 0
// to 6 bytes. Its first byte passes the command queue, then the serializer
// register. Reset (async, active low) drops any run, empties queue and serializer.
module run_length_value_encoder_core import rlve_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [15:0] sample_value_i,
  input  logic        final_sample_i,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        item_done_o,
  output logic        stream_done_o
);

  front_req_t front_req;
  cmd_t       head;
  fifo_stat_t fstat;
  logic       accept;
  logic       head_pop;

  // Input transfer: gated only by queue occupancy, never by the serializer.
  assign full   = fstat.full;
  assign accept = push & ~fstat.full;

  // Front end tracks the open run and turns each item into a byte command:
  // the closed run (value change or count cap) and, on the last value, the
  // flushed run. Items that close nothing push no command.
  rlve_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i       (accept),
    .sample_value_i,
    .final_sample_i,
    .req_o          (front_req)
  );

  // Short queue lets the front keep taking values during multi-byte bursts.
  rlve_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .req_i  (front_req),
    .pop_i  (head_pop),
    .head_o (head),
    .stat_o (fstat)
  );

  // Serializer holds one command and steps through its bytes on each pop.
  rlve_back u_back (
    .clk_i,
    .rst_ni,
    .head_i        (head),
    .head_valid_i  (~fstat.empty),
    .head_pop_o    (head_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_byte_o,
    .item_done_o,
    .stream_done_o
  );

`ifndef SYNTH
  // A final value always produces a command.
  a_final_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && final_sample_i |-> front_req.valid)
    else $error("final value produced no command");

  // Commands carry at least one run (2 bytes) and at most two (6 bytes).
  a_cmd_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_req.valid |-> (front_req.cmd.len >= 3'd2) && (front_req.cmd.len <= 3'd6))
    else $error("bad command length");

  // End of stream is only flagged on the last byte of an item.
  a_stream_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && stream_done_o |-> item_done_o)
    else $error("stream_done without item_done");

  // A full queue stays full until the serializer drains it.
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full && !head_pop |=> full)
    else $error("queue left full state without a read");
`endif

endmodule

### bench/tb_run_length_value_encoder_core.sv
// Self-checking bench for run_length_value_encoder_core: directed and random
// value streams, with a byte-level predictor that checks every output transfer.
// Depends on rlve_pkg (coding constants) and the encoder RTL.
module tb_run_length_value_encoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rlve_pkg::*;

  // Cycles with no transfer on either side before the run is declared hung.
  // At a stall of 88%, a dry spell that long has odds far below 1e-100.
  localparam int StallLimit = 2000;
  // Drain margin after the last expected byte.
  localparam int DrainCycles = 20;

  // One predicted output transfer.
  typedef struct packed {
    logic [7:0] data;
    logic       item_done;
    logic       stream_done;
  } coded_byte_t;

  // Tracks the encoder state and the bytes still owed by the DUT.
  class run_coder_model;
    logic [15:0] held_value;
    logic [7:0]  run_len;
    coded_byte_t pending[$];
    int          errors;
    int          checked;
    int          values;
    int          streams;
    int          cap_closes;

    function new();
      held_value = '0;
      run_len    = '0;
      errors     = 0;
      checked    = 0;
      values     = 0;
      streams    = 0;
      cap_closes = 0;
    endfunction

    function void append(logic [7:0] b);
      coded_byte_t c;
      c.data        = b;
      c.item_done   = 1'b0;
      c.stream_done = 1'b0;
      pending.push_back(c);
    endfunction

    // Count byte, then the value: short form if it fits 7 bits, else two
    // bytes of the value clamped to 15 bits with the long-form marker.
    function void close_run();
      logic [15:0] clamped;
      append(run_len);
      if (held_value[15:7] == '0) begin
        append(held_value[7:0]);
      end else begin
        clamped = held_value[15] ? ValueSat : held_value;
        append(LongMark | clamped[15:8]);
        append(clamped[7:0]);
      end
    endfunction

    function void note_sample(logic [15:0] value, logic last);
      int base;
      int tail;
      base = pending.size();
      values++;
      if (run_len == '0) begin
        held_value = value;
        run_len    = 8'd1;
      end else if (value == held_value && run_len != RunCap) begin
        run_len = run_len + 8'd1;
      end else begin
        if (value == held_value) cap_closes++;
        close_run();
        held_value = value;
        run_len    = 8'd1;
      end
      if (last) begin
        close_run();
        run_len    = '0;
        held_value = '0;
        streams++;
      end
      // Tag the final byte of this transfer (if any).
      if (pending.size() > base) begin
        tail = pending.size() - 1;
        pending[tail].item_done   = 1'b1;
        pending[tail].stream_done = last;
      end
    endfunction

    function void check_byte(logic [7:0] b, logic idone, logic sdone);
      coded_byte_t want;
      if (pending.size() == 0) begin
        $error("unexpected byte %02h (item_done %0b, stream_done %0b)", b, idone, sdone);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (b !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, b);
        errors++;
      end
      if (idone !== want.item_done) begin
        $error("item_done: expected %0b, got %0b", want.item_done, idone);
        errors++;
      end
      if (sdone !== want.stream_done) begin
        $error("stream_done: expected %0b, got %0b", want.stream_done, sdone);
        errors++;
      end
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        push         = 1'b0;
  logic        full;
  logic [15:0] sample_value = '0;
  logic        final_sample = 1'b0;
  logic        empty;
  logic        pop          = 1'b0;
  logic [7:0]  out_byte;
  logic        item_done;
  logic        stream_done;

  // Idle odds in percent, changed per phase by the main sequence.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;

  run_coder_model coder;

  run_length_value_encoder_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .sample_value_i (sample_value),
    .final_sample_i (final_sample),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte),
    .item_done_o    (item_done),
    .stream_done_o  (stream_done)
  );

  always #5 clk = ~clk;

  // Drive one value; returns at the falling edge after its transfer with
  // push still high so back-to-back values need no bubble. While idling,
  // the data pins carry junk to show they are ignored without push.
  task automatic push_sample(input logic [15:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push         = 1'b0;
      sample_value = 16'($urandom);
      final_sample = 1'($urandom);
      @(negedge clk);
    end
    push         = 1'b1;
    sample_value = value;
    final_sample = last;
    do @(posedge clk); while (full);
    coder.note_sample(value, last);
    @(negedge clk);
  endtask

  // Hold off the sender until every owed byte has been popped.
  task automatic drain_wait();
    push = 1'b0;
    while (coder.pending.size() != 0) @(negedge clk);
  endtask

  // Values biased toward the short/long/saturation boundaries.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(6))
      0:       return 16'($urandom_range(0, 127));
      1:       return 16'($urandom_range(128, 32767));
      2:       return 16'($urandom_range(32768, 65535));
      3: begin
        case ($urandom_range(5))
          0:       return 16'h0000;
          1:       return 16'h007F;
          2:       return 16'h0080;
          3:       return 16'h7FFF;
          4:       return 16'h8000;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed streams (runs of repeated values closed by a final
  // value), with some loose values whose final flag lands anywhere.
  task automatic random_streams(input int n_items);
    int          sent;
    int          runs;
    int          len;
    logic [15:0] v;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          push_sample(16'($urandom), $urandom_range(3) == 0);
          sent++;
        end
      end else begin
        runs = $urandom_range(1, 8);
        for (int r = 0; r < runs; r++) begin
          v   = pick_value();
          len = $urandom_range(1, 5);
          for (int k = 0; k < len; k++) begin
            push_sample(v, (r == runs - 1) && (k == len - 1));
            sent++;
          end
        end
      end
    end
  endtask

  // Output side: pop decided at the falling edge, transfer seen at the rise.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      pop = ($urandom_range(99) >= recv_stall_pct);
      @(posedge clk);
      if (pop && !empty) coder.check_byte(out_byte, item_done, stream_done);
    end
  end

  // Hang detector: counts rising edges with no transfer on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    coder = new();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: lone value stream, short-form max, long form, saturation,
    // change of value on the final item (two runs, six bytes).
    push_sample(16'h0000, 1'b1);
    push_sample(16'h007F, 1'b0);
    push_sample(16'h007F, 1'b0);
    push_sample(16'h007F, 1'b1);
    push_sample(16'h0080, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h7FFF, 1'b1);
    push_sample(16'h1234, 1'b0);
    push_sample(16'h5555, 1'b1);
    push_sample(16'h0001, 1'b0);
    push_sample(16'h0100, 1'b1);
    push_sample(16'h00FF, 1'b0);
    push_sample(16'hFF80, 1'b0);
    push_sample(16'h0000, 1'b1);
    drain_wait();

    // Run of one value long enough to hit the 255 cap mid-stream, then a
    // two-item run flushed by the final value.
    for (int k = 0; k < 257; k++) push_sample(16'h4321, k == 256);

    // Random phases: free running, sparse sender, slow receiver, both jittery.
    random_streams(55);
    drain_wait();

    send_idle_pct = 88;
    random_streams(55);
    drain_wait();

    send_idle_pct  = 0;
    recv_stall_pct = 88;
    random_streams(55);
    drain_wait();

    send_idle_pct  = 15;
    recv_stall_pct = 15;
    random_streams(55);
    drain_wait();

    repeat (DrainCycles) @(posedge clk);

    $display("tb: %0d values in, %0d streams flushed, %0d bytes checked, %0d cap closes",
             coder.values, coder.streams, coder.checked, coder.cap_closes);
    if (coder.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
